// File: rtl/srst_pkg.sv
// ----------------------------------------------------------------------------
// Sector read status table package
// Shared types, request codes, zone layout and entry reset value.
// ----------------------------------------------------------------------------
package srst_pkg;

   localparam int IDX_W = 10;
   localparam int SPT_W = 5;

   localparam logic [1:0] REQ_DATA   = 2'd0;
   localparam logic [1:0] REQ_ALLOC  = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [1:0] SLOT_BAD = 2'd3;
   localparam logic [2:0] BIT_LAST = 3'h7;

   // zone layout: last track of each zone, sectors per track, first index
   localparam logic [5:0] Z1_LAST_TRK = 6'd17;
   localparam logic [5:0] Z2_LAST_TRK = 6'd24;
   localparam logic [5:0] Z3_LAST_TRK = 6'd30;
   localparam logic [5:0] Z2_FIRST_TRK = Z1_LAST_TRK + 6'd1;
   localparam logic [5:0] Z3_FIRST_TRK = Z2_LAST_TRK + 6'd1;
   localparam logic [5:0] Z4_FIRST_TRK = Z3_LAST_TRK + 6'd1;
   localparam logic [SPT_W-1:0] Z1_SPT = 5'd21;
   localparam logic [SPT_W-1:0] Z2_SPT = 5'd19;
   localparam logic [SPT_W-1:0] Z3_SPT = 5'd18;
   localparam logic [SPT_W-1:0] Z4_SPT = 5'd17;
   localparam logic [IDX_W-1:0] Z2_BASE = 10'd357;
   localparam logic [IDX_W-1:0] Z3_BASE = 10'd490;
   localparam logic [IDX_W-1:0] Z4_BASE = 10'd598;

   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] track;
      logic [4:0] sector;
      logic [7:0] data_byte;
      logic [1:0] byte_slot;
      logic       last;
      logic [7:0] dos_error;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0] sector_index;
      logic             allocated;
      logic             was_read;
      logic             trouble;
      logic             checksum_good;
      logic             weak_res;
      logic [7:0]       last_error;
      logic [7:0]       block_checksum;
      logic             fixed;
      logic             bad_address;
   } rsp_payload_type;

   typedef struct packed {
      logic       allocated;
      logic       was_read;
      logic       trouble;
      logic       cksum_ok;
      logic       weak_flag;
      logic [7:0] last_error;
      logic [7:0] checksum;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      allocated:  1'b0,
      was_read:   1'b0,
      trouble:    1'b0,
      cksum_ok:   1'b0,
      weak_flag:  1'b0,
      last_error: 8'd1,
      checksum:   8'd0
   };

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } store_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } store_rd_type;

endpackage

// File: rtl/srst_chan_if.sv
// ----------------------------------------------------------------------------
// Sector read status table channel
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface srst_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/srst_zone.sv
// ----------------------------------------------------------------------------
// Zone decoder
// Maps a track number to its first linear index and its sector count.
// ----------------------------------------------------------------------------
module srst_zone
   import srst_pkg::*;
#(
   parameter int NUM_TRACKS = 35
) (
   input  logic [5:0]       track,
   output logic [IDX_W-1:0] first,
   output logic [SPT_W-1:0] spt,
   output logic             trk_ok
);

   logic [IDX_W-1:0] trk_w;

   assign trk_w = IDX_W'(track);

   always_comb begin
      trk_ok = (track != 6'd0) && (track <= 6'(NUM_TRACKS));
      if (track <= Z1_LAST_TRK) begin
         spt   = Z1_SPT;
         first = IDX_W'((trk_w - IDX_W'(1)) * IDX_W'(Z1_SPT));
      end else if (track <= Z2_LAST_TRK) begin
         spt   = Z2_SPT;
         first = Z2_BASE + IDX_W'((trk_w - IDX_W'(Z2_FIRST_TRK)) * IDX_W'(Z2_SPT));
      end else if (track <= Z3_LAST_TRK) begin
         spt   = Z3_SPT;
         first = Z3_BASE + IDX_W'((trk_w - IDX_W'(Z3_FIRST_TRK)) * IDX_W'(Z3_SPT));
      end else begin
         spt   = Z4_SPT;
         first = Z4_BASE + IDX_W'((trk_w - IDX_W'(Z4_FIRST_TRK)) * IDX_W'(Z4_SPT));
      end
   end

endmodule

// File: rtl/srst_store.sv
// ----------------------------------------------------------------------------
// Sector entry store
// Single-port-write, registered-read memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module srst_store
   import srst_pkg::*;
#(
   parameter int NUM_SECTORS = 683
) (
   input  logic         clock,
   input  logic         reset,
   input  store_wr_type wr,
   input  store_rd_type rd,
   output entry_type    rd_data,
   output logic         clr_busy
);

   localparam int ADDR_W = $clog2(NUM_SECTORS);

   entry_type mem [NUM_SECTORS];

   logic              clr_busy_ff;
   logic              clr_busy_in;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [ADDR_W-1:0] clr_cnt_in;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   entry_type         wdata;
   entry_type         rd_data_ff;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         if (clr_cnt_ff == ADDR_W'(NUM_SECTORS - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   assign we    = clr_busy_ff || wr.en;
   assign waddr = clr_busy_ff ? clr_cnt_ff : wr.addr[ADDR_W-1:0];
   assign wdata = clr_busy_ff ? ENTRY_RESET : wr.data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr[ADDR_W-1:0]];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

// File: rtl/sector_read_status_table.sv
// Sequence: query or last data beat via ST_DECODE, ST_READ, ST_OUT; bad address via
//   ST_DECODE, ST_OUT; a result held by rsp back-pressure stalls the sequencer
//   in ST_OUT. A data beat returns to ST_IDLE from ST_READ; an unused code stays in
//   ST_IDLE; an allocation byte visits ST_ABIT per bit and ST_AWR per in-range bit,
//   each such bit a read-modify-write of its entry; req is accepted only in ST_IDLE.
// Reset: synchronous; a clearing sweep of all NUM_SECTORS entries holds req ready low.
// ----------------------------------------------------------------------------
// Sector read status table
// Sequencer with one shared index adder/compare over a per-sector entry store.
// ----------------------------------------------------------------------------
module sector_read_status_table
   import srst_pkg::*;
#(
   parameter int NUM_TRACKS  = 35,
   parameter int NUM_SECTORS = 683
) (
   input  logic              clock,
   input  logic              reset,
   srst_chan_if.sink         req_ch,
   srst_chan_if.source       rsp_ch,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_READ   = 6'b000100,
      ST_ABIT   = 6'b001000,
      ST_AWR    = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   function automatic rsp_payload_type make_rsp(input logic [IDX_W-1:0] idx,
                                                input entry_type e);
      rsp_payload_type r;
      r.sector_index   = idx;
      r.allocated      = e.allocated;
      r.was_read       = e.was_read;
      r.trouble        = e.trouble;
      r.checksum_good  = e.cksum_ok;
      r.weak_res       = e.weak_flag;
      r.last_error     = e.last_error;
      r.block_checksum = e.checksum;
      r.fixed          = e.was_read && e.trouble && e.cksum_ok;
      r.bad_address    = 1'b0;
      return r;
   endfunction

   localparam rsp_payload_type RSP_BAD = '{bad_address: 1'b1, default: '0};

   state_type        state_ff, state_in;
   req_payload_type  pay_ff, pay_in;
   logic [7:0]       ok_code_ff, ok_code_in;
   logic [7:0]       xor_ff, xor_in;
   logic [2:0]       bit_ff, bit_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   rsp_payload_type  res_ff, res_in;
   rsp_payload_type  rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0] first;
   logic [SPT_W-1:0] spt;
   logic             trk_ok;
   logic [4:0]       off;
   logic [IDX_W:0]   sum_w;
   logic             in_rng;
   logic             clr_busy;
   entry_type        rd_data;
   entry_type        upd;
   logic             good;
   logic [7:0]       new_xor;
   store_wr_type     wr;
   store_rd_type     rd;
   logic             req_acc;
   logic             rsp_free;

   srst_zone #(
      .NUM_TRACKS (NUM_TRACKS)
   ) u_zone (
      .track  (pay_ff.track),
      .first  (first),
      .spt    (spt),
      .trk_ok (trk_ok)
   );

   srst_store #(
      .NUM_SECTORS (NUM_SECTORS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd       (rd),
      .rd_data  (rd_data),
      .clr_busy (clr_busy)
   );

   // shared index unit
   assign off    = (state_ff == ST_ABIT) ? {pay_ff.byte_slot, bit_ff} : pay_ff.sector;
   assign sum_w  = (IDX_W+1)'(first) + (IDX_W+1)'(off);
   assign in_rng = trk_ok && (off < spt) && (sum_w < (IDX_W+1)'(NUM_SECTORS));

   assign req_ch.ready = (state_ff == ST_IDLE) && !clr_busy;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign good    = (pay_ff.dos_error == ok_code_ff);
   assign new_xor = xor_ff ^ pay_ff.data_byte;

   always_comb begin
      upd = rd_data;
      if (!rd_data.was_read) begin
         upd.was_read = 1'b1;
         upd.checksum = new_xor;
         if (good) begin
            upd.cksum_ok = 1'b1;
         end else begin
            upd.trouble  = 1'b1;
            upd.cksum_ok = 1'b0;
         end
      end else if (!rd_data.trouble && !good) begin
         upd.trouble   = 1'b1;
         upd.weak_flag = 1'b1;
      end
      upd.last_error = pay_ff.dos_error;
   end

   always_comb begin
      state_in     = state_ff;
      pay_in       = pay_ff;
      ok_code_in   = csr_wr_en ? csr_wr_data : ok_code_ff;
      xor_in       = xor_ff;
      bit_in       = bit_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      wr.en        = 1'b0;
      wr.addr      = idx_ff;
      wr.data      = rd_data;
      rd.en        = 1'b0;
      rd.addr      = sum_w[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               pay_in = req_ch.payload;
               if (req_ch.payload.req_type != REQ_UNUSED) begin
                  state_in = ST_DECODE;
               end
            end
         end
         ST_DECODE: begin
            if (pay_ff.req_type == REQ_ALLOC) begin
               if (!trk_ok || pay_ff.byte_slot == SLOT_BAD) begin
                  res_in   = RSP_BAD;
                  state_in = ST_OUT;
               end else begin
                  bit_in   = '0;
                  state_in = ST_ABIT;
               end
            end else if (!in_rng) begin
               res_in   = RSP_BAD;
               state_in = ST_OUT;
            end else begin
               rd.en    = 1'b1;
               idx_in   = sum_w[IDX_W-1:0];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (pay_ff.req_type == REQ_QUERY) begin
               res_in   = make_rsp(idx_ff, rd_data);
               state_in = ST_OUT;
            end else if (!pay_ff.last) begin
               xor_in   = new_xor;
               state_in = ST_IDLE;
            end else begin
               xor_in   = '0;
               wr.en    = 1'b1;
               wr.data  = upd;
               res_in   = make_rsp(idx_ff, upd);
               state_in = ST_OUT;
            end
         end
         ST_ABIT: begin
            if (in_rng) begin
               rd.en    = 1'b1;
               idx_in   = sum_w[IDX_W-1:0];
               state_in = ST_AWR;
            end else if (bit_ff == BIT_LAST) begin
               state_in = ST_IDLE;
            end else begin
               bit_in = bit_ff + 3'd1;
            end
         end
         ST_AWR: begin
            wr.en                = 1'b1;
            wr.data.allocated    = !pay_ff.data_byte[bit_ff];
            if (bit_ff == BIT_LAST) begin
               state_in = ST_IDLE;
            end else begin
               bit_in   = bit_ff + 3'd1;
               state_in = ST_ABIT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ok_code_ff   <= 8'd1;
         xor_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ok_code_ff   <= ok_code_in;
         xor_ff       <= xor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pay_ff <= pay_in;
      bit_ff <= bit_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

endmodule
